FILE: design/pose_motion_reliability_check_unit_macros.svh
// Assertion macros for the pose motion reliability check unit
`ifndef POSE_MOTION_RELIABILITY_CHECK_UNIT_MACROS_SVH
`define POSE_MOTION_RELIABILITY_CHECK_UNIT_MACROS_SVH
// Implication checked at every rising clock edge outside reset
`define PMRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define PMRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/pmrc_pkg.sv
// Shared constants, types and functions of the pose motion reliability check
package pmrc_pkg;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned NumSteps = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
  localparam int unsigned XW = 40;
  localparam int unsigned ZW = 34;
  localparam int unsigned SqW = 60;
  localparam int unsigned SqSteps = SqW / 2;
  localparam int unsigned SqPerStage = 3;
  localparam int unsigned SqStages = SqSteps / SqPerStage;
  localparam logic [ZW-1:0] Pi30 = ZW'(64'd3373259426);
  localparam logic [ZW-1:0] HalfPi30 = ZW'(64'd1686629713);
  localparam logic [15:0] PiQ14 = 16'd51472;
  localparam logic [19:0] UsPerSec = 20'd1000000;

  typedef enum logic [1:0] {
    VerdictInvalid = 2'd0,
    VerdictValid   = 2'd1,
    VerdictSmall   = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    RegMaxSqTransRate = 2'd0,
    RegMaxAngRate     = 2'd1,
    RegMinSqTrans     = 2'd2,
    RegMinRotation    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic            xneg;
    logic            yzero;
    logic            xzero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic [ZW-1:0] atan_entry(input int unsigned i);
    logic [ZW-1:0] t;
    case (i)
      0: t = ZW'(64'd843314856);
      1: t = ZW'(64'd497837829);
      2: t = ZW'(64'd263043836);
      3: t = ZW'(64'd133525158);
      4: t = ZW'(64'd67021686);
      5: t = ZW'(64'd33543515);
      6: t = ZW'(64'd16775850);
      7: t = ZW'(64'd8388437);
      8: t = ZW'(64'd4194282);
      9: t = ZW'(64'd2097149);
      10: t = ZW'(64'd1048575);
      11: t = ZW'(64'd524287);
      12: t = ZW'(64'd262143);
      13: t = ZW'(64'd131071);
      14: t = ZW'(64'd65535);
      15: t = ZW'(64'd32767);
      16: t = ZW'(64'd16383);
      17: t = ZW'(64'd8191);
      18: t = ZW'(64'd4095);
      19: t = ZW'(64'd2047);
      20: t = ZW'(64'd1023);
      21: t = ZW'(64'd511);
      22: t = ZW'(64'd255);
      23: t = ZW'(64'd127);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input int unsigned i);
    cordic_t r;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    r = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.y > 0) begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + $signed(atan_entry(i));
    end else begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - $signed(atan_entry(i));
    end
    return r;
  endfunction

  function automatic logic [15:0] cordic_final(input cordic_t c);
    logic [ZW-1:0] z;
    logic [ZW-1:0] a;
    logic [ZW:0] s;
    if (c.z < 0) z = '0;
    else if (c.z > $signed(HalfPi30)) z = HalfPi30;
    else z = c.z;
    if (c.yzero) a = (c.xneg && !c.xzero) ? Pi30 : '0;
    else a = c.xneg ? Pi30 - z : z;
    s = {1'b0, a} + (ZW+1)'(32768);
    return s[31:16];
  endfunction
endpackage

FILE: design/pose_motion_reliability_check_unit.sv
// Top level of the pose motion reliability check unit
// channel | direction | handshake          | word
// in      | input     | in_valid/in_stall  | rotation, translation, elapsed time
// out     | output    | out_valid/out_stall| verdict, largest angle, squared distance
// cfg     | input     | cfg_valid/ready    | register index, write data
// One word per cycle while out is not stalled; 1 input register, 10 sqrt stages,
// 8 CORDIC stages, 1 angle max stage and 2 check stages, all advancing together.
// Reset clears valid bits and loads register defaults. Stall on out freezes the
// whole pipeline; in_stall is raised only while the output stage is full and stalled.
module pose_motion_reliability_check_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [15:0] rot_00_i,
  input  logic signed [15:0] rot_10_i,
  input  logic signed [15:0] rot_20_i,
  input  logic signed [15:0] rot_21_i,
  input  logic signed [15:0] rot_22_i,
  input  logic signed [15:0] trans_x_i,
  input  logic signed [15:0] trans_y_i,
  input  logic signed [15:0] trans_z_i,
  input  logic [19:0] elapsed_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [15:0] largest_angle_o,
  output logic [31:0] squared_distance_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned D = pmrc_pkg::SqStages + (pmrc_pkg::NumSteps + 1) / 2 + 1;

  logic [31:0] max_sq_rate_q;
  logic [23:0] max_ang_rate_q;
  logic [31:0] min_sq_q;
  logic [15:0] min_rot_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sq_rate_q  <= 32'd4000000;
      max_ang_rate_q <= 24'd65536;
      min_sq_q       <= 32'd10000;
      min_rot_q      <= 16'd1638;
    end else if (cfg_valid_i) begin
      case (pmrc_pkg::reg_idx_e'(cfg_index_i))
        pmrc_pkg::RegMaxSqTransRate: max_sq_rate_q  <= cfg_data_i;
        pmrc_pkg::RegMaxAngRate:     max_ang_rate_q <= cfg_data_i[23:0];
        pmrc_pkg::RegMinSqTrans:     min_sq_q       <= cfg_data_i;
        pmrc_pkg::RegMinRotation:    min_rot_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic fin_valid_q;
  assign adv = !(fin_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  logic        ang_valid;
  logic [15:0] ang;
  pmrc_angle_pipe u_angle (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_valid_i),
    .rot_00_i (rot_00_i),
    .rot_10_i (rot_10_i),
    .rot_20_i (rot_20_i),
    .rot_21_i (rot_21_i),
    .rot_22_i (rot_22_i),
    .valid_o  (ang_valid),
    .angle_o  (ang)
  );

  // distance and elapsed time travel alongside the angle pipe
  logic [31:0] dist_q [D+1];
  logic [19:0] dt_q   [D+1];
  logic [31:0] dist_d;
  logic [15:0] mx, my, mz;
  always_comb begin
    mx = trans_x_i[15] ? 16'(-trans_x_i) : trans_x_i;
    my = trans_y_i[15] ? 16'(-trans_y_i) : trans_y_i;
    mz = trans_z_i[15] ? 16'(-trans_z_i) : trans_z_i;
    dist_d = 32'(mx) * 32'(mx) + 32'(my) * 32'(my) + 32'(mz) * 32'(mz);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q[0] <= dist_d;
      dt_q[0]   <= elapsed_us_i;
      for (int k = 0; k < D; k++) begin
        dist_q[k+1] <= dist_q[k];
        dt_q[k+1]   <= dt_q[k];
      end
    end
  end

  // product stage
  logic        pv_q;
  logic [15:0] big_q;
  logic [31:0] dd_q;
  logic        dtz_q;
  logic [51:0] dist_m_q, tlim_q;
  logic [43:0] ang_m_q, alim_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (adv) begin
      pv_q <= ang_valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      big_q    <= ang;
      dd_q     <= dist_q[D];
      dtz_q    <= (dt_q[D] == '0);
      dist_m_q <= 52'(dist_q[D]) * 52'(pmrc_pkg::UsPerSec);
      tlim_q   <= 52'(max_sq_rate_q) * 52'(dt_q[D]);
      ang_m_q  <= 44'(ang) * 44'(pmrc_pkg::UsPerSec);
      alim_q   <= 44'(max_ang_rate_q) * 44'(dt_q[D]);
    end
  end

  pmrc_pkg::verdict_e verdict_d;
  logic [1:0]  verd_q;
  logic [15:0] out_ang_q;
  logic [31:0] out_dist_q;
  always_comb begin
    if (dtz_q || dist_m_q > tlim_q || ang_m_q > alim_q) verdict_d = pmrc_pkg::VerdictInvalid;
    else if (dd_q > min_sq_q || big_q > min_rot_q) verdict_d = pmrc_pkg::VerdictValid;
    else verdict_d = pmrc_pkg::VerdictSmall;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (adv) begin
      fin_valid_q <= pv_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      verd_q     <= verdict_d;
      out_ang_q  <= big_q;
      out_dist_q <= dd_q;
    end
  end

  assign out_valid_o        = fin_valid_q;
  assign verdict_o          = verd_q;
  assign largest_angle_o    = out_ang_q;
  assign squared_distance_o = out_dist_q;
endmodule

FILE: design/pmrc_angle_pipe.sv
// Pipelined square root and three vectoring CORDIC arctangents, max of magnitudes
module pmrc_angle_pipe (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic signed [15:0] rot_00_i,
  input  logic signed [15:0] rot_10_i,
  input  logic signed [15:0] rot_20_i,
  input  logic signed [15:0] rot_21_i,
  input  logic signed [15:0] rot_22_i,
  output logic        valid_o,
  output logic [15:0] angle_o
);
  localparam int unsigned S = pmrc_pkg::SqStages;
  localparam int unsigned N = pmrc_pkg::NumSteps;
  localparam int unsigned XW = pmrc_pkg::XW;

  // sqrt stages
  logic [S:0]        sv_q;
  logic [pmrc_pkg::SqW-1:0] rem_q [S+1];
  logic [pmrc_pkg::SqW-1:0] res_q [S+1];
  pmrc_pkg::cordic_t roll_q [S+1];
  pmrc_pkg::cordic_t yaw_q  [S+1];
  logic [16:0]       ay_q [S+1];

  logic [16:0] m00, m10, m20, m21, m22;
  logic [31:0] sum;
  pmrc_pkg::cordic_t roll_in, yaw_in;

  always_comb begin
    m00 = rot_00_i[15] ? 17'(-{rot_00_i[15], rot_00_i}) : {1'b0, rot_00_i};
    m10 = rot_10_i[15] ? 17'(-{rot_10_i[15], rot_10_i}) : {1'b0, rot_10_i};
    m20 = rot_20_i[15] ? 17'(-{rot_20_i[15], rot_20_i}) : {1'b0, rot_20_i};
    m21 = rot_21_i[15] ? 17'(-{rot_21_i[15], rot_21_i}) : {1'b0, rot_21_i};
    m22 = rot_22_i[15] ? 17'(-{rot_22_i[15], rot_22_i}) : {1'b0, rot_22_i};
    sum = 32'(m21) * 32'(m21) + 32'(m22) * 32'(m22);
    roll_in.xneg = rot_22_i[15];
    roll_in.xzero = (m22 == '0);
    roll_in.yzero = (m21 == '0);
    roll_in.x = XW'({m22, 14'd0});
    roll_in.y = XW'({m21, 14'd0});
    roll_in.z = '0;
    yaw_in.xneg = rot_00_i[15];
    yaw_in.xzero = (m00 == '0);
    yaw_in.yzero = (m10 == '0);
    yaw_in.x = XW'({m00, 14'd0});
    yaw_in.y = XW'({m10, 14'd0});
    yaw_in.z = '0;
  end

  // sqrt of sum << 28, kept to 60 bits: sum stays at or below 2^31 for 16 bit operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (adv_i) begin
      sv_q[0] <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0]  <= {sum, 28'd0};
      res_q[0]  <= '0;
      roll_q[0] <= roll_in;
      yaw_q[0]  <= yaw_in;
      ay_q[0]   <= m20;
    end
  end

  for (genvar g = 0; g < S; g++) begin : g_sq
    logic [pmrc_pkg::SqW-1:0] rem_d;
    logic [pmrc_pkg::SqW-1:0] res_d;
    always_comb begin
      logic [pmrc_pkg::SqW+1:0] r;
      logic [pmrc_pkg::SqW+1:0] b;
      logic [pmrc_pkg::SqW+1:0] v;
      v = {2'b0, rem_q[g]};
      r = {2'b0, res_q[g]};
      for (int k = 0; k < pmrc_pkg::SqPerStage; k++) begin
        b = (pmrc_pkg::SqW+2)'(1) << (2 * (pmrc_pkg::SqSteps - 1 - g * pmrc_pkg::SqPerStage - k));
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      rem_d = v[pmrc_pkg::SqW-1:0];
      res_d = r[pmrc_pkg::SqW-1:0];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[g+1] <= 1'b0;
      end else if (adv_i) begin
        sv_q[g+1] <= sv_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[g+1]  <= rem_d;
        res_q[g+1]  <= res_d;
        roll_q[g+1] <= roll_q[g];
        yaw_q[g+1]  <= yaw_q[g];
        ay_q[g+1]   <= ay_q[g];
      end
    end
  end

  // CORDIC stages, two steps each
  localparam int unsigned CS = (N + 1) / 2;
  logic [CS:1] cv_q;
  pmrc_pkg::cordic_t cr_q [1:CS];
  pmrc_pkg::cordic_t cp_q [1:CS];
  pmrc_pkg::cordic_t cy_q [1:CS];

  for (genvar c = 0; c < CS; c++) begin : g_cs
    logic              v_s;
    pmrc_pkg::cordic_t r_s, p_s, y_s;
    pmrc_pkg::cordic_t r_d, p_d, y_d;
    if (c == 0) begin : g_src
      always_comb begin
        v_s = sv_q[S];
        r_s = roll_q[S];
        y_s = yaw_q[S];
        p_s.xneg = 1'b0;
        p_s.xzero = (res_q[S] == '0);
        p_s.yzero = (ay_q[S] == '0);
        p_s.x = XW'(res_q[S]);
        p_s.y = XW'({ay_q[S], 14'd0});
        p_s.z = '0;
      end
    end else begin : g_src
      always_comb begin
        v_s = cv_q[c];
        r_s = cr_q[c];
        p_s = cp_q[c];
        y_s = cy_q[c];
      end
    end
    always_comb begin
      r_d = r_s;
      p_d = p_s;
      y_d = y_s;
      for (int k = 0; k < 2; k++) begin
        if (2 * c + k < N) begin
          r_d = pmrc_pkg::cordic_step(r_d, 2 * c + k);
          p_d = pmrc_pkg::cordic_step(p_d, 2 * c + k);
          y_d = pmrc_pkg::cordic_step(y_d, 2 * c + k);
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[c+1] <= 1'b0;
      end else if (adv_i) begin
        cv_q[c+1] <= v_s;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        cr_q[c+1] <= r_d;
        cp_q[c+1] <= p_d;
        cy_q[c+1] <= y_d;
      end
    end
  end

  logic [15:0] ar, ap, ay, m1;
  logic        ov_q;
  logic [15:0] big_q;
  always_comb begin
    ar = pmrc_pkg::cordic_final(cr_q[CS]);
    ap = pmrc_pkg::cordic_final(cp_q[CS]);
    ay = pmrc_pkg::cordic_final(cy_q[CS]);
    m1 = (ap > ar) ? ap : ar;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv_i) begin
      ov_q <= cv_q[CS];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      big_q <= (ay > m1) ? ay : m1;
    end
  end
  assign valid_o = ov_q;
  assign angle_o = big_q;
endmodule

FILE: design/pmrc_checker.sv
// Port checker for the pose motion reliability check unit
`include "pose_motion_reliability_check_unit_macros.svh"
module pmrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  verdict_o,
  input logic [15:0] largest_angle_o
);
  `PMRC_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `PMRC_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(verdict_o))
  `PMRC_ASSERT_IMP(a_verdict_code, clk_i, rst_ni, out_valid_o, verdict_o <= pmrc_pkg::VerdictSmall)
  `PMRC_ASSERT_IMP(a_angle_range, clk_i, rst_ni, out_valid_o, largest_angle_o <= pmrc_pkg::PiQ14)
endmodule

bind pose_motion_reliability_check_unit pmrc_checker u_pmrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .verdict_o       (verdict_o),
  .largest_angle_o (largest_angle_o)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the pose motion reliability check unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic [19:0]        dt;
  } pose_t;

  typedef struct packed {
    pmrc_pkg::verdict_e verdict;
    logic [15:0] angle;
    logic [31:0] sq_len;
  } check_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] rot_00_i = '0, rot_10_i = '0, rot_20_i = '0, rot_21_i = '0;
  logic signed [15:0] rot_22_i = '0, trans_x_i = '0, trans_y_i = '0, trans_z_i = '0;
  logic [19:0] elapsed_us_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] verdict_o;
  logic [15:0] largest_angle_o;
  logic [31:0] squared_distance_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  pose_motion_reliability_check_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  pose_t  pending_poses[$];
  check_t expected_checks[$];
  logic [31:0] lim_trans_rate, lim_ang_rate, lim_min_trans, lim_min_rot;
  bit quiet = 1'b0;
  int n_sent = 0, n_checked = 0, n_errors = 0, n_cfg = 0;
  int n_verdict[3] = '{0, 0, 0};
  int send_gap = 0, stall_gap = 0;

  localparam longint AtanQ30[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
    8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127};
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint PiQ30 = 64'sd3373259426;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] angle_mag(bit xneg, longint ax, longint ay);
    longint x, y, z, a, dx, dy;
    x = ax;
    y = ay;
    z = 0;
    if (ay == 0) begin
      a = (xneg && ax != 0) ? PiQ30 : 0;
    end else begin
      for (int i = 0; i < pmrc_pkg::CordicSteps && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += AtanQ30[i];
        end else begin
          x -= dx; y += dy; z -= AtanQ30[i];
        end
      end
      if (z < 0) z = 0;
      if (z > HalfPiQ30) z = HalfPiQ30;
      a = xneg ? PiQ30 - z : z;
    end
    return 16'((a + 32768) >> 16);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic check_t screen_pose(pose_t p);
    check_t c;
    longint r00, r10, r20, r21, r22, sq_len;
    longint unsigned den;
    logic [15:0] roll, pitch, yaw, big;
    r00 = p.r00; r10 = p.r10; r20 = p.r20; r21 = p.r21; r22 = p.r22;
    roll = angle_mag(r22 < 0, absl(r22) << 14, absl(r21) << 14);
    den = root_floor(longint'(r21 * r21 + r22 * r22) << 28);
    pitch = angle_mag(1'b0, longint'(den), absl(r20) << 14);
    yaw = angle_mag(r00 < 0, absl(r00) << 14, absl(r10) << 14);
    big = roll;
    if (pitch > big) big = pitch;
    if (yaw > big) big = yaw;
    sq_len = longint'(p.tx) * p.tx + longint'(p.ty) * p.ty + longint'(p.tz) * p.tz;
    if (p.dt == 0 || sq_len * 1000000 > longint'(lim_trans_rate) * p.dt
        || longint'(big) * 1000000 > longint'(lim_ang_rate) * p.dt)
      c.verdict = pmrc_pkg::VerdictInvalid;
    else if (sq_len > longint'(lim_min_trans) || big > lim_min_rot)
      c.verdict = pmrc_pkg::VerdictValid;
    else
      c.verdict = pmrc_pkg::VerdictSmall;
    c.angle = big;
    c.sq_len = sq_len[31:0];
    return c;
  endfunction

  function automatic logic signed [15:0] near_unit();
    logic signed [15:0] v;
    v = 16'sd16384 - 16'($urandom_range(0, 400));
    return $urandom_range(0, 7) == 0 ? -v : v;
  endfunction

  function automatic logic signed [15:0] spread(int m);
    return 16'($signed($urandom_range(0, 2 * m)) - m);
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      p.r00 = near_unit(); p.r22 = near_unit();
      p.r10 = spread(3000); p.r20 = spread(3000); p.r21 = spread(3000);
      p.tx = spread(150); p.ty = spread(150); p.tz = spread(150);
      p.dt = 20'($urandom_range(200, 200000));
    end else if (mode <= 7) begin
      p = pose_t'(148'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    end else if (mode == 8) begin
      p.r00 = spread(16384); p.r10 = spread(16384); p.r20 = spread(16384);
      p.r21 = spread(16384); p.r22 = spread(16384);
      p.tx = spread(32768); p.ty = spread(32768); p.tz = spread(32768);
      p.dt = 20'($urandom_range(0, 1000000));
    end else begin
      p.r00 = near_unit(); p.r22 = near_unit();
      p.r10 = spread(200); p.r20 = spread(200); p.r21 = spread(200);
      p.tx = spread(40); p.ty = spread(40); p.tz = spread(40);
      p.dt = 20'($urandom_range(0, 3));
    end
    return p;
  endfunction

  function automatic pose_t mk(int a, int b, int c, int d, int e, int x, int y, int z,
                               int t);
    pose_t p;
    p.r00 = 16'(a); p.r10 = 16'(b); p.r20 = 16'(c); p.r21 = 16'(d); p.r22 = 16'(e);
    p.tx = 16'(x); p.ty = 16'(y); p.tz = 16'(z); p.dt = 20'(t);
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_checks.push_back(screen_pose({rot_00_i, rot_10_i, rot_20_i, rot_21_i,
            rot_22_i, trans_x_i, trans_y_i, trans_z_i, elapsed_us_i}));
        n_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_poses.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 16);
        in_valid_i <= 1'b0;
      end else if (pending_poses.size() != 0) begin
        pose_t p;
        p = pending_poses.pop_front();
        {rot_00_i, rot_10_i, rot_20_i, rot_21_i, rot_22_i} <=
            {p.r00, p.r10, p.r20, p.r21, p.r22};
        {trans_x_i, trans_y_i, trans_z_i, elapsed_us_i} <= {p.tx, p.ty, p.tz, p.dt};
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_checks.size() == 0) begin
          $display("%0t: unexpected word verdict %0d angle %0d sq_len %0d", $time,
                   verdict_o, largest_angle_o, squared_distance_o);
          n_errors++;
        end else begin
          check_t e;
          e = expected_checks.pop_front();
          n_checked++;
          n_verdict[e.verdict]++;
          if (verdict_o !== e.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time, e.verdict, verdict_o);
            n_errors++;
          end
          if (largest_angle_o !== e.angle) begin
            $display("%0t: largest_angle expected %0d actual %0d", $time, e.angle,
                     largest_angle_o);
            n_errors++;
          end
          if (squared_distance_o !== e.sq_len) begin
            $display("%0t: squared_distance expected %0d actual %0d", $time, e.sq_len,
                     squared_distance_o);
            n_errors++;
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap <= stall_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_gap <= $urandom_range(0, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(pmrc_pkg::reg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    n_cfg++;
    case (idx)
      pmrc_pkg::RegMaxSqTransRate: lim_trans_rate = data;
      pmrc_pkg::RegMaxAngRate:     lim_ang_rate = {8'd0, data[23:0]};
      pmrc_pkg::RegMinSqTrans:     lim_min_trans = data;
      pmrc_pkg::RegMinRotation:    lim_min_rot = {16'd0, data[15:0]};
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_poses.size() != 0 || in_valid_i || expected_checks.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d);
    write_reg(pmrc_pkg::RegMaxSqTransRate, a);
    write_reg(pmrc_pkg::RegMaxAngRate, b);
    write_reg(pmrc_pkg::RegMinSqTrans, c);
    write_reg(pmrc_pkg::RegMinRotation, d);
  endtask

  initial begin
    lim_trans_rate = 4000000;
    lim_ang_rate = 65536;
    lim_min_trans = 10000;
    lim_min_rot = 1638;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_poses.push_back(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 33000));
    pending_poses.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1000));
    pending_poses.push_back(mk(-16384, 0, 0, 0, -16384, 10, 10, 10, 50000));
    pending_poses.push_back(mk(0, 16384, -16384, 16384, 0, 120, -80, 5, 1000000));
    pending_poses.push_back(mk(16384, -16384, 16384, -16384, 16384, 1, 1, 1, 0));
    pending_poses.push_back(mk(-32768, 32767, -32768, 32767, -32768, -32768, -32768,
                               -32768, 1048575));
    pending_poses.push_back(mk(32767, -32768, 32767, -32768, 32767, 32767, 32767, 32767,
                               1));
    pending_poses.push_back(mk(-16384, 0, 16384, 0, 0, 100, 0, 0, 100000));
    pending_poses.push_back(mk(16000, 1200, -800, 900, 16000, 60, 60, 60, 20000));
    pending_poses.push_back(mk(16380, 100, 50, -60, 16380, 3, -2, 1, 20000));
    pending_poses.push_back(mk(16384, 0, 0, 0, 16384, 2000, 0, 0, 1000000));
    pending_poses.push_back(mk(16384, 0, 0, 0, 16384, 100, 0, 0, 10000));
    pending_poses.push_back(mk(16384, 1700, 0, 0, 16384, 0, 0, 0, 1000000));
    for (int i = 0; i < 200; i++) pending_poses.push_back(random_pose());
    drain();
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 110; i++) pending_poses.push_back(random_pose());
    drain();
    set_limits(32'd0, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < 80; i++) pending_poses.push_back(random_pose());
    drain();
    set_limits(32'd100_000_000, 32'd400_000, 32'd5000, 32'd800);
    for (int i = 0; i < 100; i++) pending_poses.push_back(random_pose());
    drain();
    set_limits($urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < 80; i++) pending_poses.push_back(random_pose());
    drain();
    quiet = 1'b1;
    set_limits($urandom_range(1_000_000, 500_000_000), $urandom_range(10_000, 2_000_000),
               $urandom_range(0, 40_000), $urandom_range(0, 3000));
    for (int i = 0; i < 80; i++) pending_poses.push_back(random_pose());
    drain();
    $display("tb_top: %0d poses screened, %0d checked, %0d register writes", n_sent,
             n_checked, n_cfg);
    $display("tb_top: verdicts invalid %0d, new node %0d, too small %0d", n_verdict[0],
             n_verdict[1], n_verdict[2]);
    if (n_errors == 0 && expected_checks.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule
